[hdl/spe_pkg.sv]
package spe_pkg;

  localparam int MAX_TERMS = 64;
  localparam int MAX_ORDER = 15;

  localparam int IDX_W  = $clog2(MAX_TERMS);
  localparam int ITER_W = $clog2(MAX_TERMS + 1);
  localparam int CNT_W  = 7;
  localparam int ORD_W  = 4;
  localparam int COEF_W = 32;
  localparam int PT_W   = 16;
  localparam int VAL_W  = 48;
  localparam int RAM_W  = COEF_W + 2 * ORD_W;
  localparam int PC_W   = 4;

  localparam logic [ORD_W-1:0] ORD_MAX = ORD_W'(MAX_ORDER);
  localparam logic signed [PT_W-1:0] PT_ONE = 16'sh4000;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_EVAL = 1'b1;

  typedef struct packed {
    logic                     func;
    logic [IDX_W-1:0]         term_index;
    logic signed [COEF_W-1:0] term_coeff;
    logic [ORD_W-1:0]         term_x_order;
    logic [ORD_W-1:0]         term_y_order;
    logic signed [PT_W-1:0]   point_x;
    logic signed [PT_W-1:0]   point_y;
  } spe_req_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    saturated;
  } spe_rsp_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLR,
    OP_FETCH,
    OP_POWX,
    OP_SAVEX,
    OP_POWY,
    OP_MXY,
    OP_MCOEF,
    OP_RND,
    OP_ACC,
    OP_OUT
  } spe_op_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_GO,
    C_END,
    C_K_NZ,
    C_OUT_BUSY
  } spe_cond_t;

  typedef struct packed {
    spe_op_t          op;
    spe_cond_t        cond;
    logic [PC_W-1:0]  target;
  } spe_ucode_t;

  typedef struct packed {
    logic end_of_terms;
    logic k_nonzero;
    logic out_busy;
  } spe_status_t;

  localparam logic [PC_W-1:0] ST_WAIT  = PC_W'(0);
  localparam logic [PC_W-1:0] ST_TERM  = PC_W'(1);
  localparam logic [PC_W-1:0] ST_FETCH = PC_W'(2);
  localparam logic [PC_W-1:0] ST_XPOW  = PC_W'(3);
  localparam logic [PC_W-1:0] ST_SAVEX = PC_W'(4);
  localparam logic [PC_W-1:0] ST_YPOW  = PC_W'(5);
  localparam logic [PC_W-1:0] ST_MXY   = PC_W'(6);
  localparam logic [PC_W-1:0] ST_MCOEF = PC_W'(7);
  localparam logic [PC_W-1:0] ST_RND   = PC_W'(8);
  localparam logic [PC_W-1:0] ST_ACC   = PC_W'(9);
  localparam logic [PC_W-1:0] ST_DONE  = PC_W'(10);
  localparam logic [PC_W-1:0] ST_BACK  = PC_W'(11);
  localparam logic [PC_W-1:0] PROG_LEN = PC_W'(12);

  // microprogram: a step jumps to target when its condition holds, else falls through
  function automatic spe_ucode_t spe_ucode(input logic [PC_W-1:0] pc);
    unique case (pc)
      ST_WAIT:  return '{op: OP_CLR,   cond: C_NO_GO,    target: ST_WAIT};
      ST_TERM:  return '{op: OP_NONE,  cond: C_END,      target: ST_DONE};
      ST_FETCH: return '{op: OP_FETCH, cond: C_NEVER,    target: ST_WAIT};
      ST_XPOW:  return '{op: OP_POWX,  cond: C_K_NZ,     target: ST_XPOW};
      ST_SAVEX: return '{op: OP_SAVEX, cond: C_NEVER,    target: ST_WAIT};
      ST_YPOW:  return '{op: OP_POWY,  cond: C_K_NZ,     target: ST_YPOW};
      ST_MXY:   return '{op: OP_MXY,   cond: C_NEVER,    target: ST_WAIT};
      ST_MCOEF: return '{op: OP_MCOEF, cond: C_NEVER,    target: ST_WAIT};
      ST_RND:   return '{op: OP_RND,   cond: C_NEVER,    target: ST_WAIT};
      ST_ACC:   return '{op: OP_ACC,   cond: C_ALWAYS,   target: ST_TERM};
      ST_DONE:  return '{op: OP_OUT,   cond: C_OUT_BUSY, target: ST_DONE};
      ST_BACK:  return '{op: OP_NONE,  cond: C_ALWAYS,   target: ST_WAIT};
      default:  return '{op: OP_NONE,  cond: C_ALWAYS,   target: ST_WAIT};
    endcase
  endfunction

endpackage

[hdl/spe_ram.sv]
module spe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/spe_seq.sv]
module spe_seq import spe_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  spe_status_t status,
  output spe_op_t     op,
  output logic        idle
);

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  spe_ucode_t      uw;
  logic            taken;

  always_comb begin
    uw = spe_ucode(pc);
    unique case (uw.cond)
      C_NEVER:    taken = 1'b0;
      C_ALWAYS:   taken = 1'b1;
      C_NO_GO:    taken = !go;
      C_END:      taken = status.end_of_terms;
      C_K_NZ:     taken = status.k_nonzero;
      C_OUT_BUSY: taken = status.out_busy;
      default:    taken = 1'b0;
    endcase
    pc_next = taken ? uw.target : pc + PC_W'(1);
  end

  assign op   = uw.op;
  assign idle = (pc == ST_WAIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= ST_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

  a_pc_range: assert property (@(posedge clk) disable iff (rst) pc < PROG_LEN)
    else $error("step counter outside program");

  a_go_starts: assert property (@(posedge clk) disable iff (rst)
    (pc == ST_WAIT && go) |=> pc == ST_TERM)
    else $error("evaluate beat did not start the walk");

  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    (pc == ST_DONE && status.out_busy) |=> pc == ST_DONE)
    else $error("left done while result slot busy");

endmodule

[hdl/spe_dp.sv]
module spe_dp import spe_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  spe_op_t          op,
  input  logic             go,
  input  spe_req_t         req,
  input  logic [CNT_W-1:0] term_count,
  input  logic [RAM_W-1:0] rd_data,
  output logic [IDX_W-1:0] rd_addr,
  output spe_status_t      status,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output spe_rsp_t         rsp
);

  logic signed [PT_W-1:0]   px;
  logic signed [PT_W-1:0]   py;
  logic [ITER_W-1:0]        iter;
  logic [ORD_W-1:0]         k;
  logic [ORD_W-1:0]         y_ord;
  logic signed [PT_W-1:0]   p;
  logic signed [PT_W-1:0]   xp;
  logic signed [COEF_W-1:0] coeff;
  logic signed [31:0]       xy;
  logic signed [63:0]       prod;
  logic signed [COEF_W-1:0] term;
  logic signed [VAL_W-1:0]  acc;
  logic                     sat;

  logic signed [31:0]       mul_a;
  logic signed [31:0]       mul_b;
  logic signed [63:0]       mul_p;

  logic signed [32:0]       pw_rnd;
  logic signed [PT_W-1:0]   pw_val;
  logic                     pw_sat;
  logic signed [64:0]       tr_rnd;
  logic signed [COEF_W-1:0] tr_val;
  logic                     tr_sat;
  logic signed [VAL_W:0]    ac_sum;
  logic signed [VAL_W-1:0]  ac_val;
  logic                     ac_sat;

  // shared multiplier
  always_comb begin
    unique case (op)
      OP_POWX: begin
        mul_a = 32'(p);
        mul_b = 32'(px);
      end
      OP_POWY: begin
        mul_a = 32'(p);
        mul_b = 32'(py);
      end
      OP_MXY: begin
        mul_a = 32'(xp);
        mul_b = 32'(p);
      end
      OP_MCOEF: begin
        mul_a = coeff;
        mul_b = xy;
      end
      default: begin
        mul_a = 32'(p);
        mul_b = 32'(px);
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  // power step: round to q2.14, saturate
  always_comb begin
    pw_rnd = ($signed({mul_p[31], mul_p[31:0]}) + 33'sd8192) >>> 14;
    pw_sat = 1'b1;
    if (pw_rnd > 33'sd32767) begin
      pw_val = 16'sh7fff;
    end else if (pw_rnd < -33'sd32768) begin
      pw_val = 16'sh8000;
    end else begin
      pw_val = pw_rnd[PT_W-1:0];
      pw_sat = 1'b0;
    end
  end

  // term: round to q16.16, saturate
  always_comb begin
    tr_rnd = ($signed({prod[63], prod}) + 65'sd134217728) >>> 28;
    tr_sat = 1'b1;
    if (tr_rnd > 65'sd2147483647) begin
      tr_val = 32'sh7fffffff;
    end else if (tr_rnd < -65'sd2147483648) begin
      tr_val = 32'sh80000000;
    end else begin
      tr_val = tr_rnd[COEF_W-1:0];
      tr_sat = 1'b0;
    end
  end

  // saturating accumulate
  always_comb begin
    ac_sum = $signed({acc[VAL_W-1], acc})
           + $signed({{(VAL_W + 1 - COEF_W){term[COEF_W-1]}}, term});
    ac_sat = 1'b1;
    if (ac_sum > 49'sd140737488355327) begin
      ac_val = {1'b0, {(VAL_W - 1){1'b1}}};
    end else if (ac_sum < -49'sd140737488355328) begin
      ac_val = {1'b1, {(VAL_W - 1){1'b0}}};
    end else begin
      ac_val = ac_sum[VAL_W-1:0];
      ac_sat = 1'b0;
    end
  end

  assign rd_addr = iter[IDX_W-1:0];

  assign status.end_of_terms = (32'(iter) >= 32'(term_count))
                            || (32'(iter) >= 32'(MAX_TERMS));
  assign status.k_nonzero    = (k != '0);
  assign status.out_busy     = rsp_valid && !rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      iter      <= '0;
      sat       <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready && (op != OP_OUT)) begin
        rsp_valid <= 1'b0;
      end
      if (go) begin
        px <= req.point_x;
        py <= req.point_y;
      end
      unique case (op)
        OP_NONE: begin
        end
        OP_CLR: begin
          acc  <= '0;
          sat  <= 1'b0;
          iter <= '0;
        end
        OP_FETCH: begin
          coeff <= rd_data[RAM_W-1 -: COEF_W];
          k     <= rd_data[2*ORD_W-1 -: ORD_W];
          y_ord <= rd_data[ORD_W-1:0];
          p     <= PT_ONE;
        end
        OP_POWX, OP_POWY: begin
          if (k != '0) begin
            p <= pw_val;
            k <= k - ORD_W'(1);
            if (pw_sat) begin
              sat <= 1'b1;
            end
          end
        end
        OP_SAVEX: begin
          xp <= p;
          p  <= PT_ONE;
          k  <= y_ord;
        end
        OP_MXY: begin
          xy <= mul_p[31:0];
        end
        OP_MCOEF: begin
          prod <= mul_p;
        end
        OP_RND: begin
          term <= tr_val;
          if (tr_sat) begin
            sat <= 1'b1;
          end
        end
        OP_ACC: begin
          acc  <= ac_val;
          iter <= iter + ITER_W'(1);
          if (ac_sat) begin
            sat <= 1'b1;
          end
        end
        OP_OUT: begin
          if (!status.out_busy) begin
            rsp_valid     <= 1'b1;
            rsp.value     <= acc;
            rsp.saturated <= sat;
          end
        end
        default: begin
        end
      endcase
    end
  end

  a_acc_in_range: assert property (@(posedge clk) disable iff (rst)
    op == OP_ACC |-> (32'(iter) < 32'(MAX_TERMS) && 32'(iter) < 32'(term_count)))
    else $error("term added beyond the active count");

  a_out_loads: assert property (@(posedge clk) disable iff (rst)
    (op == OP_OUT && !status.out_busy) |=> rsp_valid)
    else $error("result not presented");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    op == OP_CLR |=> (!sat && acc == '0 && iter == '0))
    else $error("accumulator not cleared");

endmodule

[hdl/sparse_bivariate_poly_eval.sv]
// Sparse bivariate polynomial evaluator. A load beat (func 0) writes one term (q16.16
// coefficient, x and y exponents) into a 64-entry table. An evaluate beat (func 1)
// returns sum(coeff * x^a * y^b) over the first term_count entries at the point (x, y)
// in q2.14, as a saturated q32.16 value with a flag for any saturation on the way. A
// small microprogram drives one shared 32x32 multiplier; each power step is one pass
// through that multiplier. Only entries loaded since reset may be evaluated. The user
// must write term_count only while the block is idle; the block does not enforce it.
// Values above 64 act as 64. A finished result waits in its own register so the next
// beat can be taken meanwhile.
module sparse_bivariate_poly_eval import spe_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  spe_req_t         req,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output spe_rsp_t         rsp,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_data
);

  logic [CNT_W-1:0] term_count;
  logic             accept;
  logic             go;
  logic             ld;
  logic [ORD_W-1:0] x_ord;
  logic [ORD_W-1:0] y_ord;
  logic [RAM_W-1:0] wr_data;
  logic [RAM_W-1:0] rd_data;
  logic [IDX_W-1:0] rd_addr;
  spe_op_t          op;
  spe_status_t      status;
  logic             idle;

  always_ff @(posedge clk) begin
    if (rst) begin
      term_count <= '0;
    end else if (cfg_we) begin
      term_count <= cfg_data;
    end
  end

  assign req_ready = idle;
  assign accept    = req_valid && req_ready;
  assign go        = accept && (req.func == FUNC_EVAL);
  assign ld        = accept && (req.func == FUNC_LOAD)
                  && (32'(req.term_index) < 32'(MAX_TERMS));

  assign x_ord   = (req.term_x_order > ORD_MAX) ? ORD_MAX : req.term_x_order;
  assign y_ord   = (req.term_y_order > ORD_MAX) ? ORD_MAX : req.term_y_order;
  assign wr_data = {req.term_coeff, x_ord, y_ord};

  spe_ram #(
    .WIDTH(RAM_W),
    .DEPTH(MAX_TERMS)
  ) u_table (
    .clk  (clk),
    .we   (ld),
    .waddr(req.term_index),
    .wdata(wr_data),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  spe_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .go    (go),
    .status(status),
    .op    (op),
    .idle  (idle)
  );

  spe_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .op        (op),
    .go        (go),
    .req       (req),
    .term_count(term_count),
    .rd_data   (rd_data),
    .rd_addr   (rd_addr),
    .status    (status),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule
